FILE: rtl/core/brec_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and calendar helpers for the bcd rtc / epoch converter
// no dependencies; used by the interfaces, the alu, the sequencer and the top level
package brec_pkg;

  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned OPND_W  = 25;
  localparam int unsigned YEAR_W  = 12;

  localparam logic [YEAR_W-1:0]  BASE_YEAR     = 12'd1970;
  localparam logic [YEAR_W-1:0]  CENTURY_20    = 12'd2000;
  localparam logic [YEAR_W-1:0]  CENTURY_19    = 12'd1900;
  localparam logic [6:0]         BASE_YY       = 7'd70;
  localparam logic [6:0]         LAST_YY       = 7'd99;
  localparam logic [3:0]         LAST_MONTH    = 4'd12;
  localparam logic [OPND_W-1:0]  SECS_PER_MIN  = 25'd60;
  localparam logic [OPND_W-1:0]  SECS_PER_HOUR = 25'd3600;
  localparam logic [OPND_W-1:0]  SECS_PER_DAY  = 25'd86400;
  localparam logic [OPND_W-1:0]  SECS_ONE      = 25'd1;
  localparam logic [EPOCH_W-1:0] NEG_ONE_DAY   = 32'hFFFE_AE80;

  // restoring divide steps for the time-of-day split
  localparam logic [3:0] DAY_TOP_BIT  = 4'd8;
  localparam logic [3:0] HOUR_TOP_BIT = 4'd4;
  localparam logic [3:0] MIN_TOP_BIT  = 4'd5;

  typedef enum logic {
    ALU_MAC,
    ALU_SUB
  } brec_alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Y_YEAR,
    ST_Y_MON,
    ST_Y_DAY,
    ST_Y_HOUR,
    ST_Y_MIN,
    ST_Y_SEC,
    ST_S_YEAR,
    ST_S_MON,
    ST_S_DAY,
    ST_S_HOUR,
    ST_S_MIN,
    ST_RESULT
  } brec_state_e;

  typedef struct packed {
    logic                action;
    logic [7:0]          bcd_second;
    logic [7:0]          bcd_minute;
    logic [7:0]          bcd_hour;
    logic [7:0]          bcd_day;
    logic [7:0]          bcd_month;
    logic [7:0]          bcd_year;
    logic [EPOCH_W-1:0]  epoch_in;
  } brec_item_t;

  typedef struct packed {
    logic                to_bcd;
    logic [EPOCH_W-1:0]  epoch_out;
    logic [7:0]          out_second;
    logic [7:0]          out_minute;
    logic [7:0]          out_hour;
    logic [7:0]          out_day;
    logic [7:0]          out_month;
    logic [7:0]          out_year;
  } brec_res_t;

  typedef struct packed {
    brec_alu_op_e        op;
    logic [EPOCH_W-1:0]  acc;
    logic [7:0]          factor;
    logic [OPND_W-1:0]   operand;
  } brec_alu_req_t;

  typedef struct packed {
    logic [EPOCH_W-1:0]  result;
    logic                geq;
  } brec_alu_rsp_t;

  // years seen here lie in 1900..2126, so 2000 is the only leap century
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (y != CENTURY_19) && (y != 12'd2100);
  endfunction

  function automatic logic [OPND_W-1:0] year_secs(input logic leap);
    return leap ? 25'd31622400 : 25'd31536000;
  endfunction

  function automatic logic [OPND_W-1:0] month_secs(input logic [3:0] m, input logic leap);
    logic [OPND_W-1:0] s;
    case (m)
      4'd2:                 s = leap ? 25'd2505600 : 25'd2419200;
      4'd4, 4'd6, 4'd9,
      4'd11:                s = 25'd2592000;
      default:              s = 25'd2678400;
    endcase
    return s;
  endfunction

  // low nibble plus ten times high nibble, non-bcd nibbles taken as they are
  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    return 8'(b[3:0]) + 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0});
  endfunction

  // two low decimal digits of n; divide by ten as multiply by 205 then shift
  function automatic logic [7:0] bcd_enc(input logic [8:0] n);
    logic [16:0] p1;
    logic [5:0]  q;
    logic [3:0]  r;
    logic [13:0] p2;
    logic [2:0]  q2;
    logic [3:0]  t;
    p1 = 17'(n) * 17'd205;
    q  = p1[16:11];
    r  = 4'(n - 9'(q) * 9'd10);
    p2 = 14'(q) * 14'd205;
    q2 = p2[13:11];
    t  = 4'(q - 6'(q2) * 6'd10);
    return {t, r};
  endfunction

endpackage

FILE: rtl/core/brec_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the bcd rtc / epoch converter
// depends on brec_pkg for the epoch width
interface brec_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [7:0]                   bcd_second;
  logic [7:0]                   bcd_minute;
  logic [7:0]                   bcd_hour;
  logic [7:0]                   bcd_day;
  logic [7:0]                   bcd_month;
  logic [7:0]                   bcd_year;
  logic [brec_pkg::EPOCH_W-1:0] epoch_in;

  modport source (output valid, action, bcd_second, bcd_minute, bcd_hour, bcd_day,
                  bcd_month, bcd_year, epoch_in, input ready);
  modport sink   (input valid, action, bcd_second, bcd_minute, bcd_hour, bcd_day,
                  bcd_month, bcd_year, epoch_in, output ready);
endinterface

interface brec_out_if;
  logic                         valid;
  logic                         ready;
  logic [brec_pkg::EPOCH_W-1:0] epoch_out;
  logic [7:0]                   out_second;
  logic [7:0]                   out_minute;
  logic [7:0]                   out_hour;
  logic [7:0]                   out_day;
  logic [7:0]                   out_month;
  logic [7:0]                   out_year;

  modport source (output valid, epoch_out, out_second, out_minute, out_hour, out_day,
                  out_month, out_year, input ready);
  modport sink   (input valid, epoch_out, out_second, out_minute, out_hour, out_day,
                  out_month, out_year, output ready);
endinterface

interface brec_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] century_pivot;

  modport source (output valid, century_pivot, input ready);
  modport sink   (input valid, century_pivot, output ready);
endinterface

FILE: rtl/core/brec_alu.sv
`timescale 1ns / 1ps
// shared arithmetic unit: multiply-accumulate or compare-and-subtract on the 32-bit total
// depends on brec_pkg for the request and response structs
module brec_alu (
  input  brec_pkg::brec_alu_req_t req_i,
  output brec_pkg::brec_alu_rsp_t rsp_o
);

  logic [brec_pkg::EPOCH_W-1:0] prod;
  logic [brec_pkg::EPOCH_W-1:0] opnd_ext;

  assign prod     = brec_pkg::EPOCH_W'(req_i.factor) * brec_pkg::EPOCH_W'(req_i.operand);
  assign opnd_ext = brec_pkg::EPOCH_W'(req_i.operand);

  always_comb begin
    rsp_o.geq = (req_i.acc >= opnd_ext);
    case (req_i.op)
      brec_pkg::ALU_MAC: rsp_o.result = req_i.acc + prod;
      brec_pkg::ALU_SUB: rsp_o.result = req_i.acc - opnd_ext;
      default:           rsp_o.result = req_i.acc;
    endcase
  end

endmodule

FILE: rtl/core/brec_seq.sv
`timescale 1ns / 1ps
// sequencer and working registers: walks years, months and time-of-day steps
// through the shared alu; depends on brec_pkg
module brec_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  brec_pkg::brec_item_t    in_data_i,
  input  logic [6:0]              pivot_i,
  output brec_pkg::brec_alu_req_t alu_req_o,
  input  brec_pkg::brec_alu_rsp_t alu_rsp_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output brec_pkg::brec_res_t     res_o
);

  brec_pkg::brec_state_e state_q, state_d;

  logic                         mode_q, mode_d;
  logic [brec_pkg::EPOCH_W-1:0] acc_q, acc_d;
  logic [brec_pkg::YEAR_W-1:0]  year_q, year_d;
  logic [brec_pkg::YEAR_W-1:0]  tgt_year_q, tgt_year_d;
  logic [6:0]                   yy_q, yy_d;
  logic [3:0]                   mon_q, mon_d;
  logic [3:0]                   mon_lim_q, mon_lim_d;
  logic [3:0]                   cnt_q, cnt_d;
  logic [8:0]                   day_q, day_d;
  logic [7:0]                   hour_q, hour_d;
  logic [7:0]                   min_q, min_d;
  logic [7:0]                   sec_q, sec_d;

  logic                         leap_cur;
  logic                         leap_tgt;
  logic [7:0]                   yv;
  logic [7:0]                   mv;

  assign leap_cur = brec_pkg::is_leap(year_q);
  assign leap_tgt = brec_pkg::is_leap(tgt_year_q);
  assign yv       = brec_pkg::bcd_dec(in_data_i.bcd_year);
  assign mv       = brec_pkg::bcd_dec(in_data_i.bcd_month);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    acc_d      = acc_q;
    year_d     = year_q;
    tgt_year_d = tgt_year_q;
    yy_d       = yy_q;
    mon_d      = mon_q;
    mon_lim_d  = mon_lim_q;
    cnt_d      = cnt_q;
    day_d      = day_q;
    hour_d     = hour_q;
    min_d      = min_q;
    sec_d      = sec_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    alu_req_o.op      = brec_pkg::ALU_MAC;
    alu_req_o.acc     = acc_q;
    alu_req_o.factor  = 8'd1;
    alu_req_o.operand = '0;

    case (state_q)
      brec_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d = in_data_i.action;
          year_d = brec_pkg::BASE_YEAR;
          yy_d   = brec_pkg::BASE_YY;
          mon_d  = 4'd1;
          if (yv < {1'b0, pivot_i}) begin
            tgt_year_d = brec_pkg::CENTURY_20 + brec_pkg::YEAR_W'(yv);
          end else begin
            tgt_year_d = brec_pkg::CENTURY_19 + brec_pkg::YEAR_W'(yv);
          end
          // month zero acts as january, anything past december as december
          if (mv == 8'd0) begin
            mon_lim_d = 4'd1;
          end else if (mv > 8'(brec_pkg::LAST_MONTH)) begin
            mon_lim_d = brec_pkg::LAST_MONTH;
          end else begin
            mon_lim_d = mv[3:0];
          end
          day_d  = {1'b0, brec_pkg::bcd_dec(in_data_i.bcd_day)};
          hour_d = brec_pkg::bcd_dec(in_data_i.bcd_hour);
          min_d  = brec_pkg::bcd_dec(in_data_i.bcd_minute);
          sec_d  = brec_pkg::bcd_dec(in_data_i.bcd_second);
          if (in_data_i.action) begin
            acc_d   = in_data_i.epoch_in;
            state_d = brec_pkg::ST_S_YEAR;
          end else begin
            // start at minus one day so the day of month counts from one
            acc_d   = brec_pkg::NEG_ONE_DAY;
            state_d = brec_pkg::ST_Y_YEAR;
          end
        end
      end

      brec_pkg::ST_Y_YEAR: begin
        alu_req_o.operand = brec_pkg::year_secs(leap_cur);
        if (year_q < tgt_year_q) begin
          acc_d  = alu_rsp_i.result;
          year_d = year_q + 1'b1;
        end else begin
          state_d = brec_pkg::ST_Y_MON;
        end
      end

      brec_pkg::ST_Y_MON: begin
        alu_req_o.operand = brec_pkg::month_secs(mon_q, leap_tgt);
        if (mon_q < mon_lim_q) begin
          acc_d = alu_rsp_i.result;
          mon_d = mon_q + 1'b1;
        end else begin
          state_d = brec_pkg::ST_Y_DAY;
        end
      end

      brec_pkg::ST_Y_DAY: begin
        alu_req_o.factor  = day_q[7:0];
        alu_req_o.operand = brec_pkg::SECS_PER_DAY;
        acc_d   = alu_rsp_i.result;
        state_d = brec_pkg::ST_Y_HOUR;
      end

      brec_pkg::ST_Y_HOUR: begin
        alu_req_o.factor  = hour_q;
        alu_req_o.operand = brec_pkg::SECS_PER_HOUR;
        acc_d   = alu_rsp_i.result;
        state_d = brec_pkg::ST_Y_MIN;
      end

      brec_pkg::ST_Y_MIN: begin
        alu_req_o.factor  = min_q;
        alu_req_o.operand = brec_pkg::SECS_PER_MIN;
        acc_d   = alu_rsp_i.result;
        state_d = brec_pkg::ST_Y_SEC;
      end

      brec_pkg::ST_Y_SEC: begin
        alu_req_o.factor  = sec_q;
        alu_req_o.operand = brec_pkg::SECS_ONE;
        acc_d   = alu_rsp_i.result;
        state_d = brec_pkg::ST_RESULT;
      end

      brec_pkg::ST_S_YEAR: begin
        alu_req_o.op      = brec_pkg::ALU_SUB;
        alu_req_o.operand = brec_pkg::year_secs(leap_cur);
        if (alu_rsp_i.geq) begin
          acc_d  = alu_rsp_i.result;
          year_d = year_q + 1'b1;
          yy_d   = (yy_q == brec_pkg::LAST_YY) ? 7'd0 : yy_q + 1'b1;
        end else begin
          state_d = brec_pkg::ST_S_MON;
        end
      end

      brec_pkg::ST_S_MON: begin
        alu_req_o.op      = brec_pkg::ALU_SUB;
        alu_req_o.operand = brec_pkg::month_secs(mon_q, leap_cur);
        if ((mon_q < brec_pkg::LAST_MONTH) && alu_rsp_i.geq) begin
          acc_d = alu_rsp_i.result;
          mon_d = mon_q + 1'b1;
        end else begin
          // quotient registers fill by shifting, so clear them first
          cnt_d   = brec_pkg::DAY_TOP_BIT;
          day_d   = '0;
          hour_d  = '0;
          min_d   = '0;
          state_d = brec_pkg::ST_S_DAY;
        end
      end

      brec_pkg::ST_S_DAY: begin
        alu_req_o.op      = brec_pkg::ALU_SUB;
        alu_req_o.operand = brec_pkg::SECS_PER_DAY << cnt_q;
        if (alu_rsp_i.geq) begin
          acc_d = alu_rsp_i.result;
        end
        day_d = {day_q[7:0], alu_rsp_i.geq};
        if (cnt_q == 4'd0) begin
          cnt_d   = brec_pkg::HOUR_TOP_BIT;
          state_d = brec_pkg::ST_S_HOUR;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end

      brec_pkg::ST_S_HOUR: begin
        alu_req_o.op      = brec_pkg::ALU_SUB;
        alu_req_o.operand = brec_pkg::SECS_PER_HOUR << cnt_q;
        if (alu_rsp_i.geq) begin
          acc_d = alu_rsp_i.result;
        end
        hour_d = {hour_q[6:0], alu_rsp_i.geq};
        if (cnt_q == 4'd0) begin
          cnt_d   = brec_pkg::MIN_TOP_BIT;
          state_d = brec_pkg::ST_S_MIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end

      brec_pkg::ST_S_MIN: begin
        alu_req_o.op      = brec_pkg::ALU_SUB;
        alu_req_o.operand = brec_pkg::SECS_PER_MIN << cnt_q;
        if (alu_rsp_i.geq) begin
          acc_d = alu_rsp_i.result;
        end
        min_d = {min_q[6:0], alu_rsp_i.geq};
        if (cnt_q == 4'd0) begin
          state_d = brec_pkg::ST_RESULT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end

      brec_pkg::ST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = brec_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = brec_pkg::ST_IDLE;
      end
    endcase
  end

  // what is left in the total after the minute step is the second
  always_comb begin
    res_o.to_bcd = mode_q;
    if (mode_q) begin
      res_o.epoch_out  = '0;
      res_o.out_second = brec_pkg::bcd_enc({3'b000, acc_q[5:0]});
      res_o.out_minute = brec_pkg::bcd_enc({1'b0, min_q});
      res_o.out_hour   = brec_pkg::bcd_enc({1'b0, hour_q});
      res_o.out_day    = brec_pkg::bcd_enc(day_q + 1'b1);
      res_o.out_month  = brec_pkg::bcd_enc({5'b00000, mon_q});
      res_o.out_year   = brec_pkg::bcd_enc({2'b00, yy_q});
    end else begin
      res_o.epoch_out  = acc_q;
      res_o.out_second = '0;
      res_o.out_minute = '0;
      res_o.out_hour   = '0;
      res_o.out_day    = '0;
      res_o.out_month  = '0;
      res_o.out_year   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brec_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    acc_q      <= acc_d;
    year_q     <= year_d;
    tgt_year_q <= tgt_year_d;
    yy_q       <= yy_d;
    mon_q      <= mon_d;
    mon_lim_q  <= mon_lim_d;
    cnt_q      <= cnt_d;
    day_q      <= day_d;
    hour_q     <= hour_d;
    min_q      <= min_d;
    sec_q      <= sec_d;
  end

endmodule

FILE: rtl/core/bcd_rtc_epoch_converter_unit.sv
`timescale 1ns / 1ps
// top level of the bcd rtc / epoch converter: pivot register, sequencer, alu, output register
// depends on brec_pkg, brec_if, brec_alu and brec_seq
//
// usage:
//   in_i carries one word: action plus six packed-bcd clock bytes and epoch_in.
//   action 0 returns epoch seconds on epoch_out (bcd fields zero); action 1
//   returns packed-bcd second..year on out_o (epoch_out zero).
//   cfg_i writes century_pivot; it is always ready and should only be
//   written while no word is in flight. reset value is 70.
// sequencing:
//   one word at a time; in_i.ready is high only while the sequencer is idle.
//   bcd to seconds: one alu pass per whole year, per whole month and per
//   day/hour/minute/second term. seconds to bcd: one alu pass per year and
//   month subtracted plus 20 restoring divide steps. the sequencer returns
//   to idle after each word; the longest word is the year walk through the
//   alu up to 2126.
// reset clears the sequencer and the output valid; nothing is in flight after.
// the result sits in an output register, so a stalled receiver holds out_o
// while the next word is already accepted and worked on.
module bcd_rtc_epoch_converter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  brec_cfg_if.sink   cfg_i,
  brec_in_if.sink    in_i,
  brec_out_if.source out_o
);

  localparam logic [6:0] PIVOT_RESET = 7'd70;

  logic [6:0]              pivot_q;
  brec_pkg::brec_item_t    item;
  brec_pkg::brec_alu_req_t alu_req;
  brec_pkg::brec_alu_rsp_t alu_rsp;
  brec_pkg::brec_res_t     res;
  brec_pkg::brec_res_t     out_q;
  logic                    out_valid_q;
  logic                    res_valid;
  logic                    res_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_q <= PIVOT_RESET;
    end else if (cfg_i.valid) begin
      pivot_q <= cfg_i.century_pivot;
    end
  end

  assign item.action     = in_i.action;
  assign item.bcd_second = in_i.bcd_second;
  assign item.bcd_minute = in_i.bcd_minute;
  assign item.bcd_hour   = in_i.bcd_hour;
  assign item.bcd_day    = in_i.bcd_day;
  assign item.bcd_month  = in_i.bcd_month;
  assign item.bcd_year   = in_i.bcd_year;
  assign item.epoch_in   = in_i.epoch_in;

  brec_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (item),
    .pivot_i     (pivot_q),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  brec_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // output register frees the sequencer while the receiver stalls
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.epoch_out  = out_q.epoch_out;
  assign out_o.out_second = out_q.out_second;
  assign out_o.out_minute = out_q.out_minute;
  assign out_o.out_hour   = out_q.out_hour;
  assign out_o.out_day    = out_q.out_day;
  assign out_o.out_month  = out_q.out_month;
  assign out_o.out_year   = out_q.out_year;

  // only one word in the sequencer at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while a word is in flight");

  // a finished result always lands in the output register
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_valid_q)
    else $error("finished result lost before output register");

  // the calendar walk leaves valid decimal digits
  a_bcd_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.to_bcd) |->
      (res.out_month[7:4] <= 4'd1) && (res.out_month[3:0] <= 4'd9) &&
      (res.out_day[7:4] <= 4'd9) && (res.out_day[3:0] <= 4'd9) &&
      (res.out_hour[7:4] <= 4'd2) && (res.out_year[7:4] <= 4'd9) &&
      (res.out_minute[7:4] <= 4'd5) && (res.out_second[7:4] <= 4'd5))
    else $error("bcd result holds a digit out of range");

endmodule
